>>> hw/rtl/tfb_pkg.sv
package tfb_pkg;

  // Frame constants.
  localparam logic [7:0] LEN_BATTERY    = 8'd10;
  localparam logic [7:0] LEN_HEARTBEAT  = 8'd4;
  localparam logic [7:0] TYPE_BATTERY   = 8'h08;
  localparam logic [7:0] TYPE_HEARTBEAT = 8'h0B;
  localparam logic [7:0] CRC_POLY       = 8'hD5;
  localparam logic [7:0] ADDR_RESET     = 8'hC8;

  // Frame kinds as carried on the request's tuser bit.
  localparam logic KIND_BATTERY   = 1'b0;
  localparam logic KIND_HEARTBEAT = 1'b1;

  // Program layout.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_ENTRY   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_BAT_CRC = 4'd11;
  localparam logic [STEP_W-1:0] STEP_HB      = 4'd12;
  localparam logic [STEP_W-1:0] STEP_HB_CRC  = 4'd14;

  // Byte source chosen by a control word.
  typedef enum logic [3:0] {
    SEL_ADDR,
    SEL_LEN,
    SEL_TYPE,
    SEL_V_HI,
    SEL_V_LO,
    SEL_I_HI,
    SEL_I_LO,
    SEL_C_HI,
    SEL_C_MID,
    SEL_C_LO,
    SEL_PCT,
    SEL_ZERO,
    SEL_CRC
  } byte_sel_t;

  // One microcode word.
  typedef struct packed {
    byte_sel_t         sel;
    logic              crc_en;
    logic              last;
    logic              jump_hb;
    logic [STEP_W-1:0] target;
  } ctl_word_t;

  // Control to the CRC unit.
  typedef struct packed {
    logic clr;
    logic en;
  } crc_ctl_t;

  // The program. Battery frames run straight from the entry to the battery CRC step;
  // heartbeat frames branch after the type byte.
  function automatic ctl_word_t microcode(input logic [STEP_W-1:0] step);
    ctl_word_t w;
    w = '{sel: SEL_ZERO, crc_en: 1'b0, last: 1'b0, jump_hb: 1'b0, target: STEP_ENTRY};
    unique case (step)
      4'd0:  w.sel = SEL_ADDR;
      4'd1:  w.sel = SEL_LEN;
      4'd2:  w = '{sel: SEL_TYPE, crc_en: 1'b1, last: 1'b0, jump_hb: 1'b1, target: STEP_HB};
      4'd3:  w = '{sel: SEL_V_HI, crc_en: 1'b1, last: 1'b0, jump_hb: 1'b0, target: STEP_ENTRY};
      4'd4:  w = '{sel: SEL_V_LO, crc_en: 1'b1, last: 1'b0, jump_hb: 1'b0, target: STEP_ENTRY};
      4'd5:  w = '{sel: SEL_I_HI, crc_en: 1'b1, last: 1'b0, jump_hb: 1'b0, target: STEP_ENTRY};
      4'd6:  w = '{sel: SEL_I_LO, crc_en: 1'b1, last: 1'b0, jump_hb: 1'b0, target: STEP_ENTRY};
      4'd7:  w = '{sel: SEL_C_HI, crc_en: 1'b1, last: 1'b0, jump_hb: 1'b0, target: STEP_ENTRY};
      4'd8:  w = '{sel: SEL_C_MID, crc_en: 1'b1, last: 1'b0, jump_hb: 1'b0, target: STEP_ENTRY};
      4'd9:  w = '{sel: SEL_C_LO, crc_en: 1'b1, last: 1'b0, jump_hb: 1'b0, target: STEP_ENTRY};
      4'd10: w = '{sel: SEL_PCT, crc_en: 1'b1, last: 1'b0, jump_hb: 1'b0, target: STEP_ENTRY};
      4'd11: w = '{sel: SEL_CRC, crc_en: 1'b0, last: 1'b1, jump_hb: 1'b0, target: STEP_ENTRY};
      4'd12: w = '{sel: SEL_ZERO, crc_en: 1'b1, last: 1'b0, jump_hb: 1'b0, target: STEP_ENTRY};
      4'd13: w = '{sel: SEL_ADDR, crc_en: 1'b1, last: 1'b0, jump_hb: 1'b0, target: STEP_ENTRY};
      4'd14: w = '{sel: SEL_CRC, crc_en: 1'b0, last: 1'b1, jump_hb: 1'b0, target: STEP_ENTRY};
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

  // One byte through the CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/tfb_crc8.sv
module tfb_crc8
  import tfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  crc_ctl_t   ctl,
  input  logic [7:0] data,
  output logic [7:0] crc
);

  logic [7:0] crc_r;
  logic [7:0] crc_nxt;

  // Clear at frame start, otherwise fold in each covered byte as it leaves.
  always_comb begin
    priority if (ctl.clr) begin
      crc_nxt = 8'h00;
    end else if (ctl.en) begin
      crc_nxt = crc8_byte(crc_r, data);
    end else begin
      crc_nxt = crc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= 8'h00;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

>>> hw/rtl/telemetry_frame_builder_crc8.sv
// Telemetry frame builder with CRC-8 (polynomial 0xD5, initial value 0).
// A request beat on the in_ channel names the frame kind on in_tuser and carries the
// battery readings on in_tdata. The block then sends the frame one byte per beat on
// the out_ channel: address, length, type, big-endian payload and the CRC byte, which
// covers the type byte and the payload and is marked by out_tlast. Battery frames are
// 12 bytes, heartbeat frames 6 bytes.
// The cfg_ channel writes the address byte; it is always ready and should only be used
// between frames.
// The microcode step counter issues one byte per cycle when the receiver never stalls.
// The next request is taken in the cycle the CRC byte is issued. The first byte is
// issued from the registered request and step counter, and reaches out_tdata through
// the output register.
// Reset clears the sequencer and out_tvalid and sets the address to 0xC8.
// When the receiver stalls, the held byte stays on the output and the step counter
// waits; no request is accepted until the current frame's last byte is issued.
module telemetry_frame_builder_crc8
  import tfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // Requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,     // opcode
  input  logic [63:0] in_tdata,     // volt[15:0], curr[31:16],
                                    // cap_used[55:32], charge_left[63:56]
  // Frame bytes.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // out_byte
  output logic        out_tlast     // last
);

  logic [7:0]        addr_r;
  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              kind_r;
  logic [63:0]       item_r;
  logic              out_tvalid_r;
  logic [7:0]        out_tdata_r;
  logic              out_tlast_r;

  ctl_word_t         cw;
  logic              emit;
  logic              in_accept;
  logic [7:0]        byte_val;
  logic [7:0]        crc_val;
  crc_ctl_t          crc_ctl;

  // Address register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      addr_r <= cfg_data;
    end
  end

  // Control word of the current step; a byte is issued when the output register is free.
  assign cw        = microcode(step_r);
  assign emit      = busy_r && (!out_tvalid_r || out_tready);
  assign in_tready = !busy_r || (emit && cw.last);
  assign in_accept = in_tvalid && in_tready;

  // Byte source selection.
  always_comb begin
    unique case (cw.sel)
      SEL_ADDR:  byte_val = addr_r;
      SEL_LEN:   byte_val = (kind_r == KIND_HEARTBEAT) ? LEN_HEARTBEAT : LEN_BATTERY;
      SEL_TYPE:  byte_val = (kind_r == KIND_HEARTBEAT) ? TYPE_HEARTBEAT : TYPE_BATTERY;
      SEL_V_HI:  byte_val = item_r[15:8];
      SEL_V_LO:  byte_val = item_r[7:0];
      SEL_I_HI:  byte_val = item_r[31:24];
      SEL_I_LO:  byte_val = item_r[23:16];
      SEL_C_HI:  byte_val = item_r[55:48];
      SEL_C_MID: byte_val = item_r[47:40];
      SEL_C_LO:  byte_val = item_r[39:32];
      SEL_PCT:   byte_val = item_r[63:56];
      SEL_ZERO:  byte_val = 8'h00;
      SEL_CRC:   byte_val = crc_val;
      default:   byte_val = 8'h00;
    endcase
  end

  // Next step: a heartbeat branches after the type byte, otherwise fall through.
  always_comb begin
    if (cw.jump_hb && (kind_r == KIND_HEARTBEAT)) begin
      step_nxt = cw.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  // CRC unit: cleared by a new request, fed with each covered byte as it is issued.
  assign crc_ctl.clr = in_accept;
  assign crc_ctl.en  = emit && cw.crc_en;

  tfb_crc8 u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crc_ctl),
    .data  (byte_val),
    .crc   (crc_val)
  );

  // Sequencer state and request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_ENTRY;
    end else if (in_accept) begin
      busy_r <= 1'b1;
      step_r <= STEP_ENTRY;
    end else if (emit) begin
      busy_r <= !cw.last;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r <= in_tuser;
      item_r <= in_tdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tdata_r <= byte_val;
      out_tlast_r <= cw.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // The frame ends exactly at the CRC step of its own kind.
  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && cw.last) |->
      ((kind_r == KIND_HEARTBEAT) ? (step_r == STEP_HB_CRC) : (step_r == STEP_BAT_CRC)))
    else $error("frame ended at the wrong step");

  // The step counter never runs past the program.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= STEP_HB_CRC))
    else $error("step counter outside the program");

  // A new request always starts at the entry step with the CRC cleared.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (busy_r && (step_r == STEP_ENTRY) && (crc_val == 8'h00)))
    else $error("frame did not start cleanly");

  // Once the last byte goes out with no new request, the sequencer is idle.
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && cw.last && !in_accept) |=> !busy_r)
    else $error("sequencer still busy after last byte");

endmodule
